[hw/rtl/grid_max_falling_path_sum_top_defines.svh]
// Assertion macros for the falling path sum block.
`ifndef GRID_MAX_FALLING_PATH_SUM_TOP_DEFINES_SVH
`define GRID_MAX_FALLING_PATH_SUM_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define GMFP_ASSERT_NOW(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("gmfp check failed: %m");
`define GMFP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gmfp check failed: %m");
`else
`define GMFP_ASSERT_NOW(name, cond)
`define GMFP_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[hw/rtl/gmfp_pkg.sv]
package gmfp_pkg;

	localparam int CELL_W       = 16;
	localparam int SIZE_W       = 9;
	localparam int SUM_OUT_W    = 23;
	localparam int COL_OUT_W    = 9;
	localparam int DEF_MAX_SIZE = 256;
	localparam int QUEUE_DEPTH  = 4;

	typedef struct packed {
		logic signed [CELL_W-1:0] cell_val;
		logic [SIZE_W-1:0]        col;
		logic                     first_row;
		logic                     has_right;
		logic                     last_row;
		logic                     last_board;
	} item_t;

endpackage

[hw/rtl/gmfp_ram.sv]
module gmfp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/gmfp_queue.sv]
module gmfp_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gmfp_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output gmfp_pkg::item_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	gmfp_pkg::item_t  mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign full  = (count_q == (PW+1)'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/gmfp_front.sv]
module gmfp_front #(
	parameter int MAX_SIZE = gmfp_pkg::DEF_MAX_SIZE
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [gmfp_pkg::SIZE_W-1:0]         cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [gmfp_pkg::CELL_W-1:0]  cell_value,
	input  logic                                full,
	output logic                                push,
	output gmfp_pkg::item_t                     push_item
);

	localparam int SW = gmfp_pkg::SIZE_W;

	logic [SW-1:0] size_q;
	logic [SW-1:0] col_q;
	logic [SW-1:0] row_q;
	logic [SW-1:0] n;
	logic [SW:0]   col_inc;
	logic [SW:0]   row_inc;
	logic          last_col;
	logic          last_row;

	always_comb begin
		if (size_q == '0) begin
			n = SW'(1);
		end else if (int'(size_q) > MAX_SIZE) begin
			n = SW'(MAX_SIZE);
		end else begin
			n = size_q;
		end
		col_inc  = {1'b0, col_q} + 1'b1;
		row_inc  = {1'b0, row_q} + 1'b1;
		last_col = (col_inc >= {1'b0, n});
		last_row = (row_inc >= {1'b0, n});
	end

	assign in_stall = full;
	assign push     = in_valid && !full;

	always_comb begin
		push_item.cell_val   = cell_value;
		push_item.col        = col_q;
		push_item.first_row  = (row_q == '0);
		push_item.has_right  = !last_col;
		push_item.last_row   = last_row;
		push_item.last_board = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SW'(1);
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_wr_en) begin
			size_q <= cfg_wr_data;
			col_q  <= '0;
			row_q  <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_inc[SW-1:0];
			end else begin
				col_q <= col_inc[SW-1:0];
			end
		end
	end

endmodule

[hw/rtl/gmfp_back.sv]
module gmfp_back #(
	parameter int MAX_SIZE = gmfp_pkg::DEF_MAX_SIZE
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  restart,
	input  logic                                  q_valid,
	input  gmfp_pkg::item_t                       q_item,
	output logic                                  q_pop,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [gmfp_pkg::SUM_OUT_W-1:0]        best_sum,
	output logic [gmfp_pkg::COL_OUT_W-1:0]        best_column
);

	localparam int SW    = gmfp_pkg::SIZE_W;
	localparam int CW    = gmfp_pkg::COL_OUT_W;
	localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int SUM_W = gmfp_pkg::CELL_W + IDX_W;

	gmfp_pkg::item_t         item_s2;
	logic                    valid_s2;
	logic                    fwd_a_s2;
	logic                    fwd_b_s2;
	logic signed [SUM_W-1:0] last_sum_q;
	logic signed [SUM_W-1:0] held_q;
	logic signed [SUM_W-1:0] best_q;
	logic [CW-1:0]           best_col_q;
	logic                    out_valid_q;
	logic [gmfp_pkg::SUM_OUT_W-1:0] out_sum_q;
	logic [CW-1:0]           out_col_q;

	logic [SW-1:0]           rd_col;
	logic [SW:0]             col_inc;
	logic [IDX_W-1:0]        raddr_a;
	logic [IDX_W-1:0]        raddr_b;
	logic [IDX_W-1:0]        waddr;
	logic [SUM_W-1:0]        rdata_a;
	logic [SUM_W-1:0]        rdata_b;
	logic signed [SUM_W-1:0] up;
	logic signed [SUM_W-1:0] right;
	logic signed [SUM_W-1:0] pick;
	logic signed [SUM_W-1:0] cell_ext;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] next_best;
	logic [CW-1:0]           next_col;
	logic                    out_free;
	logic                    adv;
	logic                    retire;

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = !valid_s2 || !item_s2.last_board || out_free;
	assign q_pop    = q_valid && adv;
	assign retire   = valid_s2 && adv;

	// re-read the held cell's sums while it waits
	always_comb begin
		rd_col  = adv ? q_item.col : item_s2.col;
		col_inc = {1'b0, rd_col} + 1'b1;
		raddr_a = IDX_W'(col_inc);
		raddr_b = IDX_W'(rd_col);
		waddr   = IDX_W'(item_s2.col);
	end

	gmfp_ram #(.WIDTH(SUM_W), .DEPTH(MAX_SIZE)) u_ram_right (
		.clk   (clk),
		.we    (retire),
		.waddr (waddr),
		.wdata (sum),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	gmfp_ram #(.WIDTH(SUM_W), .DEPTH(MAX_SIZE)) u_ram_up (
		.clk   (clk),
		.we    (retire),
		.waddr (waddr),
		.wdata (sum),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	always_comb begin
		up       = fwd_b_s2 ? last_sum_q : $signed(rdata_b);
		right    = fwd_a_s2 ? last_sum_q : $signed(rdata_a);
		cell_ext = SUM_W'(item_s2.cell_val);
		pick     = up;
		if ((item_s2.col != '0) && (held_q > pick)) begin
			pick = held_q;
		end
		if (item_s2.has_right && (right > pick)) begin
			pick = right;
		end
		sum       = item_s2.first_row ? cell_ext : cell_ext + pick;
		next_best = best_q;
		next_col  = best_col_q;
		if (item_s2.last_row && (sum > best_q)) begin
			next_best = sum;
			next_col  = CW'(item_s2.col) + 1'b1;
		end
	end

	// take a new cell while the one ahead retires and writes
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s2  <= q_item;
			fwd_a_s2 <= retire && (raddr_a == waddr);
			fwd_b_s2 <= retire && (raddr_b == waddr);
		end
		if (retire) begin
			last_sum_q <= sum;
			held_q     <= up;
		end
		if (retire && item_s2.last_board) begin
			out_sum_q <= gmfp_pkg::SUM_OUT_W'(next_best);
			out_col_q <= next_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			best_q      <= '0;
			best_col_q  <= '0;
		end else begin
			if (adv) begin
				valid_s2 <= q_valid;
			end
			if (retire && item_s2.last_board) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (restart || (retire && item_s2.last_board)) begin
				best_q     <= '0;
				best_col_q <= '0;
			end else if (retire) begin
				best_q     <= next_best;
				best_col_q <= next_col;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign best_sum    = out_sum_q;
	assign best_column = out_col_q;

endmodule

[hw/rtl/grid_max_falling_path_sum_top.sv]
// Maximum falling path sum over a square board.
// Cells enter on in_valid/in_stall/cell_value, one per accepted request, in
// row-major order. board_size is written through cfg_wr_en/cfg_wr_data while
// the block is idle; a write abandons any board in progress.
// After the last cell of a board one result leaves on out_valid/out_stall
// with best_sum and best_column (1-based, 0 when no final sum exceeds zero).
// Throughput: one cell per cycle while the back is not halted by a stalled
// result, set by the single read-compute-write pass over the row-sum memory.
// After the last cell of a board is accepted it passes through the queue and
// the compute stage before the output register raises out_valid.
// The front counts rows and columns and tags each cell; a four-entry queue
// feeds the back, which reads the stored up and up-right sums, takes the
// three-way max and writes the new sum back.
// Reset: board_size returns to 1, counters and running best clear; the
// row-sum memory needs no clearing since the first row writes every entry.
// When the receiver stalls, the result holds in the output register; the back
// halts only on a cell that completes a board, and input stalls once the
// queue is full.
`include "grid_max_falling_path_sum_top_defines.svh"

module grid_max_falling_path_sum_top #(
	parameter int MAX_SIZE = gmfp_pkg::DEF_MAX_SIZE
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [gmfp_pkg::SIZE_W-1:0]          cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [gmfp_pkg::CELL_W-1:0]   cell_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [gmfp_pkg::SUM_OUT_W-1:0]       best_sum,
	output logic [gmfp_pkg::COL_OUT_W-1:0]       best_column
);

	logic            push;
	logic            full;
	logic            q_pop;
	logic            q_valid;
	gmfp_pkg::item_t push_item;
	gmfp_pkg::item_t q_item;

	gmfp_front #(.MAX_SIZE(MAX_SIZE)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cell_value  (cell_value),
		.full        (full),
		.push        (push),
		.push_item   (push_item)
	);

	gmfp_queue #(.DEPTH(gmfp_pkg::QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_item)
	);

	gmfp_back #(.MAX_SIZE(MAX_SIZE)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (cfg_wr_en),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.best_sum    (best_sum),
		.best_column (best_column)
	);

	`GMFP_ASSERT_NOW(a_pop_needs_entry, !q_pop || q_valid)
	`GMFP_ASSERT_NEXT(a_push_lands, in_valid && !in_stall, q_valid)
	`GMFP_ASSERT_NOW(a_zero_column_zero_sum, !out_valid || (best_column != '0) || (best_sum == '0))

endmodule

[verif/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SIZE     = gmfp_pkg::DEF_MAX_SIZE;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_WAIT   = 16;
	localparam int GAP_MAX      = 18;
	localparam int RANDOM_ITEMS = 180;

	typedef struct packed {
		logic [gmfp_pkg::SUM_OUT_W-1:0] sum;
		logic [gmfp_pkg::COL_OUT_W-1:0] col;
	} path_result_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_wr_en;
	logic [gmfp_pkg::SIZE_W-1:0]         cfg_wr_data;
	logic                                in_valid;
	logic                                in_stall;
	logic signed [gmfp_pkg::CELL_W-1:0]  cell_value;
	logic                                out_valid;
	logic                                out_stall;
	logic [gmfp_pkg::SUM_OUT_W-1:0]      best_sum;
	logic [gmfp_pkg::COL_OUT_W-1:0]      best_column;

	grid_max_falling_path_sum_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cell_value  (cell_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.best_sum    (best_sum),
		.best_column (best_column)
	);

	// path sum tracker
	logic signed [23:0]          path_row [MAX_SIZE];
	logic signed [23:0]          carry_left;
	int unsigned                 row_pos;
	int unsigned                 col_pos;
	logic signed [23:0]          lead_sum;
	int unsigned                 lead_col;
	logic [gmfp_pkg::SIZE_W-1:0] size_reg;

	path_result_t due_results[$];

	int  fail_count;
	int  cycle_count;
	int  cells_sent;
	int  results_seen;
	int  cfg_writes;
	bit  tx_gaps;
	bit  rx_gaps;
	int  hold_left;
	int  stall_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned board_dim(logic [gmfp_pkg::SIZE_W-1:0] sz);
		if (sz == 0)
			return 1;
		if (sz > MAX_SIZE)
			return MAX_SIZE;
		return sz;
	endfunction

	function automatic void restart_paths();
		carry_left = '0;
		row_pos    = 0;
		col_pos    = 0;
		lead_sum   = '0;
		lead_col   = 0;
	endfunction

	function automatic void advance_path_sums(logic signed [gmfp_pkg::CELL_W-1:0] cell_in);
		int unsigned        n;
		int unsigned        j;
		logic signed [23:0] old;
		logic signed [23:0] top;
		logic signed [23:0] sum;
		path_result_t       res;
		n   = board_dim(size_reg);
		j   = col_pos;
		old = path_row[j];
		if (row_pos == 0) begin
			sum = cell_in;
		end else begin
			top = old;
			if (j > 0 && carry_left > top)
				top = carry_left;
			if (j + 1 < n && path_row[j + 1] > top)
				top = path_row[j + 1];
			sum = cell_in + top;
		end
		carry_left  = old;
		path_row[j] = sum;
		if (row_pos + 1 >= n && sum > lead_sum) begin
			lead_sum = sum;
			lead_col = j + 1;
		end
		if (j + 1 < n) begin
			col_pos = j + 1;
		end else begin
			col_pos    = 0;
			carry_left = '0;
			if (row_pos + 1 < n) begin
				row_pos++;
			end else begin
				res.sum = lead_sum[gmfp_pkg::SUM_OUT_W-1:0];
				res.col = lead_col[gmfp_pkg::COL_OUT_W-1:0];
				due_results.push_back(res);
				restart_paths();
			end
		end
	endfunction

	function automatic logic signed [gmfp_pkg::CELL_W-1:0] draw_cell(int mode);
		int r;
		case (mode)
			1: begin
				r = $urandom_range(0, 8);
				r = r - 4;
			end
			2: begin
				r = $urandom;
				r = r | 32'h8000;
			end
			3: begin
				r = $urandom_range(30000, 32767);
			end
			default: begin
				r = $urandom;
			end
		endcase
		return r[gmfp_pkg::CELL_W-1:0];
	endfunction

	function automatic int draw_gap();
		if (!tx_gaps)
			return 0;
		return $urandom_range(0, GAP_MAX);
	endfunction

	task automatic send_cell(input logic signed [gmfp_pkg::CELL_W-1:0] v, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		cell_value <= v;
		do
			@(posedge clk);
		while (in_stall);
		advance_path_sums(v);
		cells_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_board_size(input logic [gmfp_pkg::SIZE_W-1:0] v);
		wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (DRAIN_WAIT) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		size_reg = v;
		restart_paths();
		cfg_writes++;
	endtask

	// receiver: the random stall counts down only while a result is waiting; the hold-off counts down unconditionally
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			if (out_valid)
				stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		path_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (due_results.size() == 0) begin
				$error("result with no request pending: best_sum %0d best_column %0d",
					best_sum, best_column);
				fail_count++;
			end else begin
				exp_res = due_results.pop_front();
				if (best_sum !== exp_res.sum) begin
					$error("best_sum expected %0d actual %0d", exp_res.sum, best_sum);
					fail_count++;
				end
				if (best_column !== exp_res.col) begin
					$error("best_column expected %0d actual %0d", exp_res.col, best_column);
					fail_count++;
				end
			end
			stall_left = rx_gaps ? $urandom_range(0, GAP_MAX) : 0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("grid_max_falling_path_sum_top verification failed");
			$finish;
		end
	end

	task automatic test_single_cell_boards();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		send_cell(16'sh7FFF, draw_gap());
		send_cell(-16'sh8000, draw_gap());
		send_cell(16'sh0000, draw_gap());
		send_cell(16'sh0001, draw_gap());
		send_cell(-16'sh0001, draw_gap());
		write_board_size(9'd0);
		send_cell(16'sh1234, draw_gap());
		send_cell(-16'sh0042, draw_gap());
	endtask

	task automatic test_ties_and_abandon();
		write_board_size(9'd2);
		send_cell(16'sd5, draw_gap());
		send_cell(16'sd5, draw_gap());
		send_cell(16'sd1, draw_gap());
		send_cell(16'sd1, draw_gap());
		write_board_size(9'd3);
		send_cell(16'sd100, draw_gap());
		send_cell(-16'sd7, draw_gap());
		send_cell(16'sd3, draw_gap());
		send_cell(16'sd9, draw_gap());
		write_board_size(9'd3);
		send_cell(16'sh7FFF, draw_gap());
		send_cell(-16'sh8000, draw_gap());
		send_cell(16'sh7FFF, draw_gap());
		send_cell(-16'sh8000, draw_gap());
		send_cell(16'sh7FFF, draw_gap());
		send_cell(-16'sh8000, draw_gap());
		send_cell(16'sh7FFF, draw_gap());
		send_cell(16'sh7FFF, draw_gap());
		send_cell(-16'sh8000, draw_gap());
	endtask

	task automatic test_backpressure();
		write_board_size(9'd1);
		tx_gaps   = 1'b0;
		hold_left = 300;
		repeat (20) send_cell(draw_cell(0), 0);
		wait_drained();
		write_board_size(9'd3);
		hold_left = 200;
		repeat (36) send_cell(draw_cell(3), 0);
		wait_drained();
		tx_gaps = 1'b1;
	endtask

	task automatic test_full_size();
		int unsigned n;
		n = MAX_SIZE;
		tx_gaps = 1'b1;
		write_board_size(9'd256);
		repeat (8) send_cell(draw_cell(0), draw_gap());
		tx_gaps = 1'b0;
		write_board_size(9'd511);
		repeat (n + 4) send_cell(draw_cell($urandom_range(0, 3)), 0);
		wait_drained();
		tx_gaps = 1'b1;
	endtask

	task automatic test_random_boards();
		int          sent;
		int          pick;
		int          sz;
		int          mode;
		int          boards;
		int          cells;
		int unsigned n;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 5)
				sz = 0;
			else if (pick < 75)
				sz = $urandom_range(1, 5);
			else if (pick < 95)
				sz = $urandom_range(6, 9);
			else
				sz = $urandom_range(10, 14);
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_gaps = ($urandom_range(0, 3) != 0);
			mode    = $urandom_range(0, 3);
			write_board_size(sz[gmfp_pkg::SIZE_W-1:0]);
			n      = board_dim(sz[gmfp_pkg::SIZE_W-1:0]);
			boards = (n > 8) ? 1 : $urandom_range(1, 4);
			cells  = boards * n * n;
			if (n > 1 && $urandom_range(0, 7) == 0)
				cells += $urandom_range(1, n * n - 1);
			repeat (cells) begin
				if ($urandom_range(0, 9) == 0)
					mode = $urandom_range(0, 3);
				send_cell(draw_cell(mode), draw_gap());
				sent++;
			end
		end
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		cell_value  = '0;
		out_stall   = 1'b0;
		fail_count   = 0;
		cycle_count  = 0;
		cells_sent   = 0;
		results_seen = 0;
		cfg_writes   = 0;
		tx_gaps      = 1'b1;
		rx_gaps      = 1'b1;
		hold_left    = 0;
		stall_left   = 0;
		size_reg     = 9'd1;
		foreach (path_row[k])
			path_row[k] = '0;
		restart_paths();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_cell_boards();
		test_ties_and_abandon();
		test_backpressure();
		test_full_size();
		test_random_boards();

		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("run sent %0d cells with %0d board size writes, %0d results checked",
			cells_sent, cfg_writes, results_seen);
		$display("sizes from 0 to 511, long output hold-offs and gap-free bursts included");
		if (fail_count == 0 && due_results.size() == 0) begin
			$display("grid_max_falling_path_sum_top verification clean");
		end else begin
			$display("grid_max_falling_path_sum_top verification failed");
		end
		$finish;
	end

endmodule
